>>> rtl/nec_ir_frame_decoder_assert.svh
// Assertion macros shared by the NEC IR frame decoder modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Check a property at every clock edge outside reset
`define NIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define NIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nir_pkg.sv
// Package for the NEC IR frame decoder: widths, register map, phase codes
// and the structs passed between the front, back and register modules.
package nir_pkg;

  // Frame and field sizes
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned CMD_W      = 8;

  // Configuration port
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = $clog2(NUM_REGS * 4);
  localparam int unsigned IDX_W      = $clog2(NUM_REGS);

  // Queues between front, back and the result port
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  // Register reset values, microseconds
  localparam logic [TIME_W-1:0] RST_LEADER_MARK_MIN  = 16'd8500;
  localparam logic [TIME_W-1:0] RST_LEADER_MARK_MAX  = 16'd9500;
  localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MIN = 16'd4000;
  localparam logic [TIME_W-1:0] RST_LEADER_SPACE_MAX = 16'd5000;
  localparam logic [TIME_W-1:0] RST_PULSE_MIN        = 16'd400;
  localparam logic [TIME_W-1:0] RST_BIT_MARK_MAX     = 16'd700;
  localparam logic [TIME_W-1:0] RST_BIT_SPACE_MAX    = 16'd1800;
  localparam logic [TIME_W-1:0] RST_ONE_THRESHOLD    = 16'd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_LEADER_MARK_MIN  = 3'd0,
    REG_LEADER_MARK_MAX  = 3'd1,
    REG_LEADER_SPACE_MIN = 3'd2,
    REG_LEADER_SPACE_MAX = 3'd3,
    REG_PULSE_MIN        = 3'd4,
    REG_BIT_MARK_MAX     = 3'd5,
    REG_BIT_SPACE_MAX    = 3'd6,
    REG_ONE_THRESHOLD    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LMARK  = 3'd1,
    PH_LSPACE = 3'd2,
    PH_BMARK  = 3'd3,
    PH_BSPACE = 3'd4
  } phase_e;

  typedef enum logic {
    EV_EDGE    = 1'b0,
    EV_TIMEOUT = 1'b1
  } ev_kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] leader_mark_min;
    logic [TIME_W-1:0] leader_mark_max;
    logic [TIME_W-1:0] leader_space_min;
    logic [TIME_W-1:0] leader_space_max;
    logic [TIME_W-1:0] pulse_min;
    logic [TIME_W-1:0] bit_mark_max;
    logic [TIME_W-1:0] bit_space_max;
    logic [TIME_W-1:0] one_threshold;
  } cfg_t;

  // Classified edge event: window checks done against the current settings
  typedef struct packed {
    ev_kind_e kind;
    logic     lmark_ok;
    logic     lspace_ok;
    logic     bmark_ok;
    logic     bspace_ok;
    logic     bit_one;
  } ev_t;

  typedef struct packed {
    logic              code_valid;
    logic              frame_error;
    logic [CODE_W-1:0] frame_code;
  } res_t;

  // Strict window test, both bounds exclusive
  function automatic logic in_window(logic [TIME_W-1:0] v, logic [TIME_W-1:0] lo,
                                     logic [TIME_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

endpackage

>>> rtl/nec_ir_frame_decoder.sv
// NEC infrared frame decoder, top level.
// Event channel: push/full with mode_i (0 edge, 1 timer overflow) and
// interval_us_i, the microseconds since the previous edge. An event is taken
// at a clock edge with push high and full low.
// Result channel: empty/pop. Every event yields exactly one result:
// code_valid_o with frame_code_o and command_byte_o when the event closed a
// 32-bit frame, frame_error_o when it aborted a frame; all zero otherwise.
// A result passes through the event queue and then the result queue before it
// can be popped from the result ports.
// Throughput: one event per cycle unless pop is held low and the queues fill;
// the frame state machine steps once per event, and the front classifies
// intervals against the windows in the same cycle as it takes the event.
// Two-entry queues sit between front and back and in front of the result
// ports; when pop is held low the result queue fills, then the event queue,
// and only then does full rise.
// Reset empties both queues, returns the decoder to idle and loads the
// default windows. The APB-style port holds eight 16-bit window registers at
// byte addresses 0 to 28; write them only while no event is in flight.
module nec_ir_frame_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode_i,
  input  logic [nir_pkg::TIME_W-1:0]  interval_us_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        code_valid_o,
  output logic [nir_pkg::CODE_W-1:0]  frame_code_o,
  output logic [nir_pkg::CMD_W-1:0]   command_byte_o,
  output logic                        frame_error_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nir_pkg::ADDR_W-1:0]  paddr,
  input  logic [nir_pkg::DATA_W-1:0]  pwdata,
  output logic [nir_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import nir_pkg::*;

  cfg_t cfg;
  ev_t  ev;
  logic ev_valid;
  logic ev_pop;
  res_t res;

  assign pready = 1'b1;

  nir_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  nir_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .interval_us_i (interval_us_i),
    .ev_valid_o    (ev_valid),
    .ev_o          (ev),
    .ev_pop_i      (ev_pop)
  );

  nir_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ev_valid_i (ev_valid),
    .ev_i       (ev),
    .ev_pop_o   (ev_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  // Drive the result ports from the head of the result queue
  assign code_valid_o   = res.code_valid;
  assign frame_code_o   = res.frame_code;
  assign command_byte_o = res.frame_code[15:8];
  assign frame_error_o  = res.frame_error;

endmodule

>>> rtl/nir_cfg_regs.sv
// Timing window registers of the NEC IR frame decoder behind an APB-style port.
// Depends on nir_pkg.
module nir_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nir_pkg::ADDR_W-1:0]  paddr,
  input  logic [nir_pkg::DATA_W-1:0]  pwdata,
  output logic [nir_pkg::DATA_W-1:0]  prdata,
  output nir_pkg::cfg_t               cfg_o
);
  import nir_pkg::*;

  cfg_t              cfg_q, cfg_d;
  reg_idx_e          idx;
  logic              wr_en;
  logic [TIME_W-1:0] wval;
  logic [TIME_W-1:0] rval;

  assign idx   = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[TIME_W-1:0];

  // Update the addressed register on the access phase of a write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_LEADER_MARK_MIN:  cfg_d.leader_mark_min  = wval;
        REG_LEADER_MARK_MAX:  cfg_d.leader_mark_max  = wval;
        REG_LEADER_SPACE_MIN: cfg_d.leader_space_min = wval;
        REG_LEADER_SPACE_MAX: cfg_d.leader_space_max = wval;
        REG_PULSE_MIN:        cfg_d.pulse_min        = wval;
        REG_BIT_MARK_MAX:     cfg_d.bit_mark_max     = wval;
        REG_BIT_SPACE_MAX:    cfg_d.bit_space_max    = wval;
        REG_ONE_THRESHOLD:    cfg_d.one_threshold    = wval;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  // Select the read value
  always_comb begin
    unique case (idx)
      REG_LEADER_MARK_MIN:  rval = cfg_q.leader_mark_min;
      REG_LEADER_MARK_MAX:  rval = cfg_q.leader_mark_max;
      REG_LEADER_SPACE_MIN: rval = cfg_q.leader_space_min;
      REG_LEADER_SPACE_MAX: rval = cfg_q.leader_space_max;
      REG_PULSE_MIN:        rval = cfg_q.pulse_min;
      REG_BIT_MARK_MAX:     rval = cfg_q.bit_mark_max;
      REG_BIT_SPACE_MAX:    rval = cfg_q.bit_space_max;
      REG_ONE_THRESHOLD:    rval = cfg_q.one_threshold;
      default:              rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W - TIME_W){1'b0}}, rval};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_min  <= RST_LEADER_MARK_MIN;
      cfg_q.leader_mark_max  <= RST_LEADER_MARK_MAX;
      cfg_q.leader_space_min <= RST_LEADER_SPACE_MIN;
      cfg_q.leader_space_max <= RST_LEADER_SPACE_MAX;
      cfg_q.pulse_min        <= RST_PULSE_MIN;
      cfg_q.bit_mark_max     <= RST_BIT_MARK_MAX;
      cfg_q.bit_space_max    <= RST_BIT_SPACE_MAX;
      cfg_q.one_threshold    <= RST_ONE_THRESHOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/nir_front.sv
// Front end of the NEC IR frame decoder: classifies each event against the
// timing windows and holds it in a two-entry queue. Depends on nir_pkg.
module nir_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nir_pkg::cfg_t               cfg_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        mode_i,
  input  logic [nir_pkg::TIME_W-1:0]  interval_us_i,
  output logic                        ev_valid_o,
  output nir_pkg::ev_t                ev_o,
  input  logic                        ev_pop_i
);
  import nir_pkg::*;

  ev_t               ev_in;
  ev_t               ev_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              wr_en;

  // Classify the interval against every window at once
  always_comb begin
    ev_in.kind      = ev_kind_e'(mode_i);
    ev_in.lmark_ok  = in_window(interval_us_i, cfg_i.leader_mark_min,
                                cfg_i.leader_mark_max);
    ev_in.lspace_ok = in_window(interval_us_i, cfg_i.leader_space_min,
                                cfg_i.leader_space_max);
    ev_in.bmark_ok  = in_window(interval_us_i, cfg_i.pulse_min, cfg_i.bit_mark_max);
    ev_in.bspace_ok = in_window(interval_us_i, cfg_i.pulse_min, cfg_i.bit_space_max);
    ev_in.bit_one   = interval_us_i > cfg_i.one_threshold;
  end

  assign full_o     = count_q == QCNT_W'(QDEPTH);
  assign wr_en      = push_i && !full_o;
  assign ev_valid_o = count_q != '0;
  assign ev_o       = ev_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_en    ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = ev_pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(wr_en) - QCNT_W'(ev_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified event
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ev_q[wr_ptr_q] <= ev_in;
    end
  end

`include "nec_ir_frame_decoder_assert.svh"

  `NIR_ASSERT(a_evq_cnt_range, count_q <= QCNT_W'(QDEPTH), "event queue overfilled")
  `NIR_ASSERT(a_evq_no_underflow, ev_pop_i |-> count_q != '0, "pop from empty event queue")
  `NIR_ASSERT_NEXT(a_evq_push_lands, wr_en && !ev_pop_i, count_q == $past(count_q) + QCNT_W'(1), "event push lost")

endmodule

>>> rtl/nir_back.sv
// Back end of the NEC IR frame decoder: frame state machine, code shift
// register and the two-entry result queue. Depends on nir_pkg.
module nir_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ev_valid_i,
  input  nir_pkg::ev_t  ev_i,
  output logic          ev_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output nir_pkg::res_t res_o
);
  import nir_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  bits_q, bits_d;
  logic [CODE_W-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]  cnt_inc;
  logic              busy;
  logic              win_ok;
  phase_e            phase_nxt;
  logic              go;
  res_t              res_d;

  res_t              res_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              rd_en;

  // Take an event only when the result queue has room for its transaction
  assign go       = ev_valid_i && (count_q != QCNT_W'(QDEPTH));
  assign ev_pop_o = go;
  assign cnt_inc  = bits_q + CNT_W'(1);

  // Pick the window and the following phase for the current phase
  always_comb begin
    unique case (phase_q)
      PH_LMARK: begin
        busy = 1'b1; win_ok = ev_i.lmark_ok;  phase_nxt = PH_LSPACE;
      end
      PH_LSPACE: begin
        busy = 1'b1; win_ok = ev_i.lspace_ok; phase_nxt = PH_BMARK;
      end
      PH_BMARK: begin
        busy = 1'b1; win_ok = ev_i.bmark_ok;  phase_nxt = PH_BSPACE;
      end
      PH_BSPACE: begin
        busy = 1'b1; win_ok = ev_i.bspace_ok; phase_nxt = PH_BMARK;
      end
      default: begin
        busy = 1'b0; win_ok = 1'b0;           phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Next state and result for one event
  always_comb begin
    phase_d = phase_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    res_d   = '0;
    if (go) begin
      if (ev_i.kind == EV_TIMEOUT) begin
        // Overflow aborts a frame in progress, ignored while idle
        res_d.frame_error = busy;
        phase_d           = PH_IDLE;
      end else if (!busy) begin
        // First edge opens a frame
        bits_d  = '0;
        shift_d = '0;
        phase_d = PH_LMARK;
      end else if (!win_ok) begin
        res_d.frame_error = 1'b1;
        phase_d           = PH_IDLE;
      end else if (phase_q == PH_BSPACE) begin
        shift_d = {shift_q[CODE_W-2:0], ev_i.bit_one};
        bits_d  = cnt_inc;
        if (cnt_inc >= CNT_W'(FRAME_BITS)) begin
          res_d.code_valid = 1'b1;
          res_d.frame_code = shift_d;
          phase_d          = PH_IDLE;
        end else begin
          phase_d = phase_nxt;
        end
      end else begin
        phase_d = phase_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bits_q  <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
    end
  end

  // Result queue: one entry written for every event taken
  assign empty_o = count_q == '0;
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = res_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = go    ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(go) - QCNT_W'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      res_q[wr_ptr_q] <= res_d;
    end
  end

`include "nec_ir_frame_decoder_assert.svh"

  `NIR_ASSERT(a_resq_cnt_range, count_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `NIR_ASSERT(a_res_excl, go |-> !(res_d.code_valid && res_d.frame_error), "code and error together")
  `NIR_ASSERT(a_res_code_zero, (go && !res_d.code_valid) |-> res_d.frame_code == '0, "stray code bits")
  `NIR_ASSERT_NEXT(a_done_idle, go && res_d.code_valid, phase_q == PH_IDLE, "no return to idle after frame")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the NEC IR frame decoder: drives edge and timeout
// events through the push/full port, predicts each result, checks them in order.
// Depends on nir_pkg and the nec_ir_frame_decoder top level.
module tb_top;
  import nir_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned ROUND_EVENTS  = 150;
  localparam int unsigned FRAME_EVENTS  = 2 + 2 * FRAME_BITS; // after the start edge

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [CMD_W-1:0]  cmd;
    logic              err;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic                mode_i;
  logic [TIME_W-1:0]   interval_us_i;
  logic                empty;
  logic                pop;
  logic                code_valid_o;
  logic [CODE_W-1:0]   frame_code_o;
  logic [CMD_W-1:0]    command_byte_o;
  logic                frame_error_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Decoder state and window settings as the bench tracks them
  phase_e              dec_phase;
  int                  bits_seen;
  logic [CODE_W-1:0]   code_acc;
  logic [TIME_W-1:0]   win [NUM_REGS];
  logic [TIME_W-1:0]   default_win [NUM_REGS];

  outcome_t            pending_results [$];
  int                  events_sent;
  int                  mismatches;
  int                  stall_cycles;
  int                  hold_left;
  logic                hold_request;
  logic                push_gaps_on;
  logic                pop_gaps_on;

  nec_ir_frame_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .interval_us_i  (interval_us_i),
    .empty          (empty),
    .pop            (pop),
    .code_valid_o   (code_valid_o),
    .frame_code_o   (frame_code_o),
    .command_byte_o (command_byte_o),
    .frame_error_o  (frame_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Strict window test, both bounds excluded
  function automatic logic strictly_between(logic [TIME_W-1:0] v, logic [TIME_W-1:0] lo,
                                            logic [TIME_W-1:0] hi);
    return (v > lo) && (v < hi);
  endfunction

  // Advance the tracked decoder by one event and return the result it gives
  function automatic outcome_t step_decoder(ev_kind_e kind, logic [TIME_W-1:0] t);
    outcome_t res;
    logic     ok;
    res = '0;
    if (kind == EV_TIMEOUT) begin
      res.err   = (dec_phase != PH_IDLE);
      dec_phase = PH_IDLE;
    end else if (dec_phase == PH_IDLE) begin
      bits_seen = 0;
      code_acc  = '0;
      dec_phase = PH_LMARK;
    end else begin
      case (dec_phase)
        PH_LMARK:  ok = strictly_between(t, win[REG_LEADER_MARK_MIN], win[REG_LEADER_MARK_MAX]);
        PH_LSPACE: ok = strictly_between(t, win[REG_LEADER_SPACE_MIN],
                                         win[REG_LEADER_SPACE_MAX]);
        PH_BMARK:  ok = strictly_between(t, win[REG_PULSE_MIN], win[REG_BIT_MARK_MAX]);
        default:   ok = strictly_between(t, win[REG_PULSE_MIN], win[REG_BIT_SPACE_MAX]);
      endcase
      if (!ok) begin
        res.err   = 1'b1;
        dec_phase = PH_IDLE;
      end else if (dec_phase == PH_BSPACE) begin
        code_acc  = {code_acc[CODE_W-2:0], t > win[REG_ONE_THRESHOLD]};
        bits_seen = bits_seen + 1;
        if (bits_seen >= FRAME_BITS) begin
          res.valid = 1'b1;
          res.code  = code_acc;
          res.cmd   = code_acc[15:8];
          dec_phase = PH_IDLE;
        end else begin
          dec_phase = PH_BMARK;
        end
      end else begin
        dec_phase = phase_e'(dec_phase + 3'd1);
      end
    end
    return res;
  endfunction

  // A value inside (lo, hi), hugging the bounds half of the time; a random value when the window holds none
  function automatic logic [TIME_W-1:0] pick_inside(int lo, int hi);
    int r;
    r = $urandom_range(3);
    if (hi - lo < 2) return TIME_W'($urandom);
    if (r == 0) return TIME_W'(lo + 1);
    if (r == 1) return TIME_W'(hi - 1);
    return TIME_W'($urandom_range(hi - 1, lo + 1));
  endfunction

  // A value that fails the window (lo, hi), often right on a bound
  function automatic logic [TIME_W-1:0] pick_outside(int lo, int hi);
    case ($urandom_range(3))
      0:       return TIME_W'(lo);
      1:       return TIME_W'(hi);
      2:       return TIME_W'($urandom_range(lo, 0));
      default: return TIME_W'($urandom_range(65535, hi));
    endcase
  endfunction

  task automatic report_error(string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one event, idling first at random, and log its expected result on acceptance
  task automatic send_event(ev_kind_e kind, logic [TIME_W-1:0] t);
    while (push_gaps_on && $urandom_range(99) < 18) begin
      @(negedge clk_i);
      push <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    push          <= 1'b1;
    mode_i        <= kind;
    interval_us_i <= t;
    do @(posedge clk_i); while (full);
    pending_results.push_back(step_decoder(kind, t));
    events_sent++;
  endtask

  // Send a whole frame for code; break_at names the event that spoils it, 0 keeps it intact
  task automatic send_frame(logic [CODE_W-1:0] code, int break_at);
    int   lo;
    int   hi;
    logic bit_val;
    send_event(EV_EDGE, TIME_W'($urandom));
    for (int idx = 1; idx <= FRAME_EVENTS; idx++) begin
      bit_val = 1'b0;
      if (idx == 1) begin
        lo = win[REG_LEADER_MARK_MIN];
        hi = win[REG_LEADER_MARK_MAX];
      end else if (idx == 2) begin
        lo = win[REG_LEADER_SPACE_MIN];
        hi = win[REG_LEADER_SPACE_MAX];
      end else if (idx % 2 == 1) begin
        lo = win[REG_PULSE_MIN];
        hi = win[REG_BIT_MARK_MAX];
      end else begin
        lo      = win[REG_PULSE_MIN];
        hi      = win[REG_BIT_SPACE_MAX];
        bit_val = code[FRAME_BITS - 1 - (idx - 4) / 2];
      end
      if (idx == break_at) begin
        if ($urandom_range(2) == 0) send_event(EV_TIMEOUT, TIME_W'($urandom));
        else send_event(EV_EDGE, pick_outside(lo, hi));
        return;
      end
      // Narrow a bit space to the side of the threshold that gives the wanted bit
      if (idx > 2 && idx % 2 == 0) begin
        if (bit_val) lo = (win[REG_ONE_THRESHOLD] > lo) ? win[REG_ONE_THRESHOLD] : lo;
        else hi = (win[REG_ONE_THRESHOLD] + 1 < hi) ? win[REG_ONE_THRESHOLD] + 1 : hi;
      end
      send_event(EV_EDGE, pick_inside(lo, hi));
    end
  endtask

  // Write one window register through the APB-style port
  task automatic write_window(reg_idx_e idx, logic [TIME_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    win[idx] = val;
  endtask

  // Drop push and wait until every expected result has come out
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic restore_defaults();
    for (int i = 0; i < NUM_REGS; i++) write_window(reg_idx_e'(i), default_win[i]);
  endtask

  task automatic randomise_windows();
    int lo;
    int pmin;
    int bsmax;
    lo = $urandom_range(60000);
    write_window(REG_LEADER_MARK_MIN, TIME_W'(lo));
    write_window(REG_LEADER_MARK_MAX, TIME_W'(lo + 2 + ($urandom_range(1) ? 0 :
                                                         $urandom_range(4000))));
    lo = $urandom_range(60000);
    write_window(REG_LEADER_SPACE_MIN, TIME_W'(lo));
    write_window(REG_LEADER_SPACE_MAX, TIME_W'(lo + 2 + $urandom_range(4000)));
    pmin  = $urandom_range(30000);
    bsmax = pmin + 4 + $urandom_range(6000);
    write_window(REG_PULSE_MIN, TIME_W'(pmin));
    write_window(REG_BIT_MARK_MAX, TIME_W'(pmin + 2 + $urandom_range(3000)));
    write_window(REG_BIT_SPACE_MAX, TIME_W'(bsmax));
    write_window(REG_ONE_THRESHOLD, TIME_W'($urandom_range(bsmax - 2, pmin + 1)));
  endtask

  // Single events at the window bounds with the reset settings
  task automatic test_event_edges();
    send_event(EV_TIMEOUT, 16'hFFFF);
    send_event(EV_TIMEOUT, 16'h0000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'd8500);
    send_event(EV_EDGE, 16'hFFFF);
    send_event(EV_EDGE, 16'd9500);
    send_event(EV_EDGE, 16'h5A5A);
    send_event(EV_EDGE, 16'd8501);
    send_event(EV_EDGE, 16'd4000);
    send_event(EV_EDGE, 16'h0001);
    send_event(EV_EDGE, 16'd9499);
    send_event(EV_EDGE, 16'd4999);
    send_event(EV_EDGE, 16'd400);
    send_event(EV_EDGE, 16'h8000);
    send_event(EV_EDGE, 16'd9000);
    send_event(EV_EDGE, 16'd4500);
    send_event(EV_EDGE, 16'd401);
    send_event(EV_EDGE, 16'd1800);
    send_event(EV_EDGE, 16'h7FFF);
    send_event(EV_EDGE, 16'd9001);
    send_event(EV_EDGE, 16'd4001);
    send_event(EV_EDGE, 16'd699);
    send_event(EV_TIMEOUT, 16'h1234);
    send_event(EV_EDGE, 16'd700);
  endtask

  task automatic test_clean_frames();
    send_frame(32'h0000_0000, 0);
    send_frame(32'hFFFF_FFFF, 0);
    send_frame(32'h00FF_A25D, 0);
  endtask

  // Widest windows, empty windows and the threshold at both ends
  task automatic test_window_extremes();
    settle();
    write_window(REG_LEADER_MARK_MIN, 16'h0000);
    write_window(REG_LEADER_MARK_MAX, 16'hFFFF);
    write_window(REG_LEADER_SPACE_MIN, 16'h0000);
    write_window(REG_LEADER_SPACE_MAX, 16'hFFFF);
    write_window(REG_PULSE_MIN, 16'h0000);
    write_window(REG_BIT_MARK_MAX, 16'hFFFF);
    write_window(REG_BIT_SPACE_MAX, 16'hFFFF);
    write_window(REG_ONE_THRESHOLD, 16'h0000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'hFFFF);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'h0001);
    send_event(EV_EDGE, 16'hFFFE);
    send_event(EV_EDGE, 16'h0001);
    send_event(EV_EDGE, 16'hFFFE);
    send_event(EV_EDGE, 16'hFFFE);
    send_event(EV_EDGE, 16'h0001);
    send_event(EV_TIMEOUT, 16'h0000);
    send_frame($urandom, 0);
    settle();
    write_window(REG_ONE_THRESHOLD, 16'hFFFF);
    send_frame(32'h0000_0000, 0);
    send_frame($urandom, $urandom_range(FRAME_EVENTS, 1));
    settle();
    write_window(REG_LEADER_MARK_MIN, 16'hFFFF);
    write_window(REG_LEADER_MARK_MAX, 16'h0000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'h8000);
    settle();
    write_window(REG_LEADER_MARK_MIN, 16'd1000);
    write_window(REG_LEADER_MARK_MAX, 16'd1000);
    send_event(EV_EDGE, 16'h0000);
    send_event(EV_EDGE, 16'd1000);
    settle();
    restore_defaults();
  endtask

  // Mostly well-formed frames with random codes, some spoilt, the rest noise
  task automatic test_random_traffic();
    int round_end;
    for (int round = 0; round < 3; round++) begin
      settle();
      if (round == 0) restore_defaults();
      else randomise_windows();
      round_end = events_sent + ROUND_EVENTS;
      while (events_sent < round_end) begin
        if ($urandom_range(99) < 75)
          send_frame($urandom, ($urandom_range(99) < 30) ? $urandom_range(FRAME_EVENTS, 1) : 0);
        else
          send_event(ev_kind_e'($urandom_range(1)), TIME_W'($urandom));
      end
    end
  endtask

  // Back-to-back transactions on both sides
  task automatic test_steady_flow();
    settle();
    restore_defaults();
    push_gaps_on = 1'b0;
    pop_gaps_on  = 1'b0;
    send_frame($urandom, 0);
    send_frame($urandom, 0);
    settle();
    push_gaps_on = 1'b1;
    pop_gaps_on  = 1'b1;
  endtask

  // Hold the result side off so that the block fills and stalls its input
  task automatic test_backpressure();
    settle();
    push_gaps_on = 1'b0;
    hold_request = 1'b1;
    send_frame($urandom, 0);
    push_gaps_on = 1'b1;
    settle();
  endtask

  // Result side: random idling, plus a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (!rst_ni || hold_left > 0) begin
      pop <= 1'b0;
      if (hold_left > 0) hold_left--;
    end else if (pop_gaps_on && $urandom_range(99) < 18) begin
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_result
    outcome_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_error("result with no event pending");
      end else begin
        want = pending_results.pop_front();
        if (code_valid_o !== want.valid)
          report_error($sformatf("code_valid %b, want %b", code_valid_o, want.valid));
        if (frame_code_o !== want.code)
          report_error($sformatf("frame_code %h, want %h", frame_code_o, want.code));
        if (command_byte_o !== want.cmd)
          report_error($sformatf("command_byte %h, want %h", command_byte_o, want.cmd));
        if (frame_error_o !== want.err)
          report_error($sformatf("frame_error %b, want %b", frame_error_o, want.err));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    mode_i        = 1'b0;
    interval_us_i = '0;
    pop           = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_request  = 1'b0;
    hold_left     = 0;
    push_gaps_on  = 1'b1;
    pop_gaps_on   = 1'b1;
    events_sent   = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    default_win[REG_LEADER_MARK_MIN]  = RST_LEADER_MARK_MIN;
    default_win[REG_LEADER_MARK_MAX]  = RST_LEADER_MARK_MAX;
    default_win[REG_LEADER_SPACE_MIN] = RST_LEADER_SPACE_MIN;
    default_win[REG_LEADER_SPACE_MAX] = RST_LEADER_SPACE_MAX;
    default_win[REG_PULSE_MIN]        = RST_PULSE_MIN;
    default_win[REG_BIT_MARK_MAX]     = RST_BIT_MARK_MAX;
    default_win[REG_BIT_SPACE_MAX]    = RST_BIT_SPACE_MAX;
    default_win[REG_ONE_THRESHOLD]    = RST_ONE_THRESHOLD;
    win       = default_win;
    dec_phase = PH_IDLE;
    bits_seen = 0;
    code_acc  = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_event_edges();
    test_clean_frames();
    test_window_extremes();
    test_random_traffic();
    test_steady_flow();
    test_backpressure();
    settle();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
